// ===== rtl/two_relay_thermostat_assert.svh =====
// Assertion macros for the two-relay thermostat checker.
`ifndef TWO_RELAY_THERMOSTAT_ASSERT_SVH
`define TWO_RELAY_THERMOSTAT_ASSERT_SVH

// cond must never hold outside reset
`define TRT_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("thermostat check failed");

// ante implies cons in the same cycle
`define TRT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thermostat check failed");

// ante implies cons in the next cycle
`define TRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thermostat check failed");

`endif

// ===== rtl/trt_pkg.sv =====
// Types, register map and reset constants of the two-relay thermostat.
package trt_pkg;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  localparam logic [2:0] REG_TEMP_TRIM    = 3'd0;
  localparam logic [2:0] REG_HYSTERESIS   = 3'd1;
  localparam logic [2:0] REG_OFF_BAND     = 3'd2;
  localparam logic [2:0] REG_SETPOINT_MIN = 3'd3;
  localparam logic [2:0] REG_SETPOINT_MAX = 3'd4;

  localparam logic [7:0] RST_TEMP_TRIM    = 8'd37;
  localparam logic [7:0] RST_HYSTERESIS   = 8'd10;
  localparam logic [7:0] RST_OFF_BAND     = 8'd5;
  localparam logic [6:0] RST_SETPOINT_MIN = 7'd16;
  localparam logic [6:0] RST_SETPOINT_MAX = 7'd35;
  localparam logic [6:0] RST_SETPOINT     = 7'd24;

  typedef enum logic [1:0] {
    KIND_TEMP   = 2'd0,
    KIND_FAIL   = 2'd1,
    KIND_BUTTON = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] temp_trim;
    logic [7:0] hysteresis;
    logic [7:0] off_band;
    logic [6:0] setpoint_min;
    logic [6:0] setpoint_max;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [11:0] raw_temperature;
    logic               up_button;
    logic               down_button;
  } item_t;

  typedef struct packed {
    logic               heat;
    logic               cool;
    logic               fault;
    logic [6:0]         setpoint;
    logic signed [11:0] temp;
  } status_t;

endpackage

// ===== rtl/two_relay_thermostat.sv =====
// Top level of the two-relay heat/cool thermostat.
// One transaction is accepted per clock unless the input stalls. Each
// is captured in an input register and applied to the state once no result
// waits or the waiting one is taken; the result stays until taken.
// While a result waits the input register takes one more transaction, then
// the input stalls until the result is taken. The state registers (relays,
// fault, setpoint, stored corrected temperature) are the result register.
// Write configuration over APB only while idle; block does not enforce it.
module two_relay_thermostat
  import trt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           kind_i,
  input  logic signed [11:0]   raw_temperature_i,
  input  logic                 up_button_i,
  input  logic                 down_button_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 heat_relay_o,
  output logic                 cool_relay_o,
  output logic                 sensor_fault_o,
  output logic [6:0]           setpoint_now_o,
  output logic signed [11:0]   corrected_temp_o
);

  cfg_t    cfg;
  status_t status;
  item_t   item_q;
  logic    in_valid_q, in_valid_d;
  logic    out_valid_q, out_valid_d;
  logic    advance;
  logic    fire;
  logic    accept;

  trt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  trt_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .status_o (status)
  );

  assign advance     = !out_valid_q || !out_stall_i;
  assign fire        = in_valid_q && advance;
  assign in_stall_o  = in_valid_q && !advance;
  assign accept      = in_valid_i && !in_stall_o;
  assign in_valid_d  = accept || (in_valid_q && !fire);
  assign out_valid_d = fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.kind            <= kind_i;
      item_q.raw_temperature <= raw_temperature_i;
      item_q.up_button       <= up_button_i;
      item_q.down_button     <= down_button_i;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign heat_relay_o     = status.heat;
  assign cool_relay_o     = status.cool;
  assign sensor_fault_o   = status.fault;
  assign setpoint_now_o   = status.setpoint;
  assign corrected_temp_o = status.temp;

endmodule

// ===== rtl/trt_cfg.sv =====
// APB configuration registers of the thermostat.
module trt_cfg
  import trt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[AddrWidth-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_TEMP_TRIM:    cfg_d.temp_trim    = pwdata[7:0];
        REG_HYSTERESIS:   cfg_d.hysteresis   = pwdata[7:0];
        REG_OFF_BAND:     cfg_d.off_band     = pwdata[7:0];
        REG_SETPOINT_MIN: cfg_d.setpoint_min = pwdata[6:0];
        REG_SETPOINT_MAX: cfg_d.setpoint_max = pwdata[6:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TEMP_TRIM:    prdata = {24'd0, cfg_q.temp_trim};
      REG_HYSTERESIS:   prdata = {24'd0, cfg_q.hysteresis};
      REG_OFF_BAND:     prdata = {24'd0, cfg_q.off_band};
      REG_SETPOINT_MIN: prdata = {25'd0, cfg_q.setpoint_min};
      REG_SETPOINT_MAX: prdata = {25'd0, cfg_q.setpoint_max};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_trim    <= RST_TEMP_TRIM;
      cfg_q.hysteresis   <= RST_HYSTERESIS;
      cfg_q.off_band     <= RST_OFF_BAND;
      cfg_q.setpoint_min <= RST_SETPOINT_MIN;
      cfg_q.setpoint_max <= RST_SETPOINT_MAX;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/trt_core.sv =====
// Thermostat state and single-pass update of relays, fault, setpoint and temperature.
module trt_core
  import trt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output status_t status_o
);

  // returns {heat, cool}
  function automatic logic [1:0] eval_relays(
    input logic [1:0]         cur,
    input logic [6:0]         tgt,
    input logic signed [11:0] t,
    input logic [7:0]         hyst,
    input logic [7:0]         band
  );
    logic [10:0]        centre;
    logic signed [12:0] c13;
    logic signed [12:0] t13;
    logic signed [12:0] h13;
    logic signed [12:0] b13;
    logic [1:0]         res;
    centre = {1'b0, tgt, 3'b000} + {3'b000, tgt, 1'b0};
    c13    = $signed({2'b00, centre});
    t13    = $signed({t[11], t});
    h13    = $signed({5'd0, hyst});
    b13    = $signed({5'd0, band});
    res    = cur;
    if (t13 < c13 - h13) begin
      res = 2'b10;
    end else if (t13 > c13 + h13) begin
      res = 2'b01;
    end else if (t13 >= c13 - b13 && t13 <= c13 + b13) begin
      res = 2'b00;
    end
    return res;
  endfunction

  logic [1:0]         relay_q, relay_d;
  logic               fault_q, fault_d;
  logic [6:0]         target_q, target_d;
  logic signed [11:0] temp_q, temp_d;
  logic               up_held_q, up_held_d;
  logic               down_held_q, down_held_d;

  logic signed [12:0] corr;
  logic [6:0]         tgt_up;
  logic [1:0]         rel_up;

  always_comb begin
    relay_d     = relay_q;
    fault_d     = fault_q;
    target_d    = target_q;
    temp_d      = temp_q;
    up_held_d   = up_held_q;
    down_held_d = down_held_q;
    corr        = $signed({item_i.raw_temperature[11], item_i.raw_temperature})
                  - $signed({5'd0, cfg_i.temp_trim});
    tgt_up      = target_q;
    rel_up      = relay_q;
    case (item_i.kind)
      KIND_TEMP: begin
        temp_d  = (corr[12] != corr[11]) ? 12'sh800 : corr[11:0];
        fault_d = 1'b0;
        relay_d = eval_relays(relay_q, target_q, temp_d, cfg_i.hysteresis, cfg_i.off_band);
      end
      KIND_FAIL: begin
        fault_d = 1'b1;
        relay_d = 2'b00;
      end
      KIND_BUTTON: begin
        up_held_d   = item_i.up_button;
        down_held_d = item_i.down_button;
        if (item_i.up_button && !up_held_q && target_q < cfg_i.setpoint_max) begin
          tgt_up = target_q + 7'd1;
          if (!fault_q) begin
            rel_up = eval_relays(relay_q, tgt_up, temp_q, cfg_i.hysteresis, cfg_i.off_band);
          end
        end
        target_d = tgt_up;
        relay_d  = rel_up;
        if (item_i.down_button && !down_held_q && tgt_up > cfg_i.setpoint_min) begin
          target_d = tgt_up - 7'd1;
          if (!fault_q) begin
            relay_d = eval_relays(rel_up, target_d, temp_q, cfg_i.hysteresis, cfg_i.off_band);
          end
        end
      end
      default: begin
        relay_d = relay_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_q     <= 2'b00;
      fault_q     <= 1'b0;
      target_q    <= RST_SETPOINT;
      temp_q      <= '0;
      up_held_q   <= 1'b0;
      down_held_q <= 1'b0;
    end else if (fire_i) begin
      relay_q     <= relay_d;
      fault_q     <= fault_d;
      target_q    <= target_d;
      temp_q      <= temp_d;
      up_held_q   <= up_held_d;
      down_held_q <= down_held_d;
    end
  end

  assign status_o.heat     = relay_q[1];
  assign status_o.cool     = relay_q[0];
  assign status_o.fault    = fault_q;
  assign status_o.setpoint = target_q;
  assign status_o.temp     = temp_q;

endmodule

// ===== rtl/trt_checker.sv =====
// Port-level checks of the thermostat, bound to the top level.
`include "two_relay_thermostat_assert.svh"

module trt_checker
  import trt_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               heat_relay_o,
  input logic               cool_relay_o,
  input logic               sensor_fault_o,
  input logic [6:0]         setpoint_now_o,
  input logic signed [11:0] corrected_temp_o
);

  logic [22:0] payload;
  assign payload = {heat_relay_o, cool_relay_o, sensor_fault_o, setpoint_now_o,
                    corrected_temp_o};

  `TRT_ASSERT_NEVER(a_relays_exclusive, clk_i, rst_ni, heat_relay_o && cool_relay_o)
  `TRT_ASSERT_IMPL(a_fault_relays_off, clk_i, rst_ni, sensor_fault_o, !heat_relay_o && !cool_relay_o)
  `TRT_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(payload))

endmodule

bind two_relay_thermostat trt_checker u_trt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .heat_relay_o     (heat_relay_o),
  .cool_relay_o     (cool_relay_o),
  .sensor_fault_o   (sensor_fault_o),
  .setpoint_now_o   (setpoint_now_o),
  .corrected_temp_o (corrected_temp_o)
);

// ===== tb/sv/tb_two_relay_thermostat.sv =====
// Self-checking testbench for the two-relay thermostat: directed table, then random phases.
`timescale 1ns / 1ps

module tb_two_relay_thermostat;
  import trt_pkg::*;

  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned PHASE_ITEMS = 170;
  localparam int unsigned NUM_PHASES  = 8;

  typedef struct {
    item_t   it;
    bit      known;
    status_t want;
  } table_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [1:0]           kind_i;
  logic signed [11:0]   raw_temperature_i;
  logic                 up_button_i;
  logic                 down_button_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 heat_relay_o;
  logic                 cool_relay_o;
  logic                 sensor_fault_o;
  logic [6:0]           setpoint_now_o;
  logic signed [11:0]   corrected_temp_o;

  // thermostat state as predicted
  cfg_t       cfg;
  logic       heat_q;
  logic       cool_q;
  logic       fault_q;
  logic       up_seen;
  logic       down_seen;
  logic [6:0] setpoint_q;
  int         stored_temp;

  status_t     status_due[$];
  table_row_t  rows[$];
  bit          hold_req;
  int unsigned burst_left;
  int unsigned mismatches;
  int unsigned checked;
  int unsigned quiet_cycles;
  int unsigned cfg_settings;
  int unsigned kind_count[4];

  two_relay_thermostat dut (.*);

  always #1 clk_i = ~clk_i;

  function automatic void update_relays();
    int mid;
    mid = int'(setpoint_q) * 10;
    if (stored_temp < mid - int'(cfg.hysteresis)) begin
      heat_q = 1'b1;
      cool_q = 1'b0;
    end else if (stored_temp > mid + int'(cfg.hysteresis)) begin
      cool_q = 1'b1;
      heat_q = 1'b0;
    end else if (stored_temp >= mid - int'(cfg.off_band) &&
                 stored_temp <= mid + int'(cfg.off_band)) begin
      heat_q = 1'b0;
      cool_q = 1'b0;
    end
  endfunction

  function automatic status_t thermostat_next(item_t it);
    int      t;
    status_t s;
    case (it.kind)
      KIND_TEMP: begin
        t = int'($signed(it.raw_temperature)) - int'(cfg.temp_trim);
        if (t < -2048) t = -2048;
        if (t > 2047) t = 2047;
        stored_temp = t;
        fault_q = 1'b0;
        update_relays();
      end
      KIND_FAIL: begin
        fault_q = 1'b1;
        heat_q = 1'b0;
        cool_q = 1'b0;
      end
      KIND_BUTTON: begin
        // up press handled before down press
        if (it.up_button) begin
          if (!up_seen) begin
            up_seen = 1'b1;
            if (setpoint_q < cfg.setpoint_max) begin
              setpoint_q = setpoint_q + 7'd1;
              if (!fault_q) update_relays();
            end
          end
        end else begin
          up_seen = 1'b0;
        end
        if (it.down_button) begin
          if (!down_seen) begin
            down_seen = 1'b1;
            if (setpoint_q > cfg.setpoint_min) begin
              setpoint_q = setpoint_q - 7'd1;
              if (!fault_q) update_relays();
            end
          end
        end else begin
          down_seen = 1'b0;
        end
      end
      default: ;
    endcase
    s.heat = heat_q;
    s.cool = cool_q;
    s.fault = fault_q;
    s.setpoint = setpoint_q;
    s.temp = stored_temp[11:0];
    return s;
  endfunction

  function automatic void add_row(logic [1:0] k, int raw, bit up, bit dn, bit known,
                                  bit h, bit c, bit f, int sp, int t);
    table_row_t r;
    r.it.kind = k;
    r.it.raw_temperature = raw[11:0];
    r.it.up_button = up;
    r.it.down_button = dn;
    r.known = known;
    r.want.heat = h;
    r.want.cool = c;
    r.want.fault = f;
    r.want.setpoint = sp[6:0];
    r.want.temp = t[11:0];
    rows.push_back(r);
  endfunction

  // samples mostly near the switching points, some anywhere in the 12-bit range
  function automatic item_t random_item();
    item_t it;
    int    raw;
    int    span;
    int    pick;
    pick = int'($urandom_range(99));
    it.raw_temperature = 12'($urandom_range(4095));
    it.up_button = 1'($urandom_range(1));
    it.down_button = 1'($urandom_range(1));
    if (pick < 50) begin
      it.kind = KIND_TEMP;
      if ($urandom_range(9) != 0) begin
        span = int'(cfg.hysteresis) + 15;
        if (int'(cfg.off_band) + 15 > span) span = int'(cfg.off_band) + 15;
        raw = int'(cfg.temp_trim) + int'(setpoint_q) * 10
              + int'($urandom_range(2 * span)) - span;
        if (raw < -2048) raw = -2048;
        if (raw > 2047) raw = 2047;
        it.raw_temperature = raw[11:0];
      end
    end else if (pick < 60) begin
      it.kind = KIND_FAIL;
    end else if (pick < 95) begin
      it.kind = KIND_BUTTON;
    end else begin
      it.kind = KIND_UNUSED;
    end
    return it;
  endfunction

  function automatic void compare_field(string name, logic signed [11:0] want_v,
                                        logic signed [11:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endfunction

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] readback;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    readback = '0;
    case (idx)
      REG_TEMP_TRIM: begin
        cfg.temp_trim = value[7:0];
        readback = {24'd0, value[7:0]};
      end
      REG_HYSTERESIS: begin
        cfg.hysteresis = value[7:0];
        readback = {24'd0, value[7:0]};
      end
      REG_OFF_BAND: begin
        cfg.off_band = value[7:0];
        readback = {24'd0, value[7:0]};
      end
      REG_SETPOINT_MIN: begin
        cfg.setpoint_min = value[6:0];
        readback = {25'd0, value[6:0]};
      end
      REG_SETPOINT_MAX: begin
        cfg.setpoint_max = value[6:0];
        readback = {25'd0, value[6:0]};
      end
      default: ;
    endcase
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== readback) begin
      $display("%0t: register %0d expected %0d, got %0d", $time, idx, readback, prdata);
      mismatches++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_item(input item_t it, input bit known, input status_t want);
    int unsigned gap;
    status_t     s;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(3) == 0) ? $urandom_range(30, 8) : $urandom_range(4);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    kind_i <= it.kind;
    raw_temperature_i <= it.raw_temperature;
    up_button_i <= it.up_button;
    down_button_i <= it.down_button;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    s = thermostat_next(it);
    status_due.push_back(known ? want : s);
    kind_count[it.kind]++;
  endtask

  task automatic wait_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic configure(input int off, input int hyst, input int band,
                           input int lo, input int hi);
    wait_results();
    apb_write(REG_TEMP_TRIM, 32'(off));
    apb_write(REG_HYSTERESIS, 32'(hyst));
    apb_write(REG_OFF_BAND, 32'(band));
    apb_write(REG_SETPOINT_MIN, 32'(lo));
    apb_write(REG_SETPOINT_MAX, 32'(hi));
    cfg_settings++;
  endtask

  // receiver: stall density changes in stretches, long hold-off on request
  initial begin : receiver
    int unsigned stall_pct;
    int unsigned run_left;
    int unsigned hold_left;
    stall_pct = 0;
    run_left = 0;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(60, 8);
          case ($urandom_range(3))
            0:       stall_pct = 0;
            1:       stall_pct = 20;
            2:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        run_left--;
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    status_t got;
    status_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {heat_relay_o, cool_relay_o, sensor_fault_o, setpoint_now_o, corrected_temp_o};
      if (status_due.size() == 0) begin
        $display("%0t: unexpected result heat=%b cool=%b fault=%b setpoint=%0d temp=%0d",
                 $time, got.heat, got.cool, got.fault, got.setpoint, got.temp);
        mismatches++;
      end else begin
        want = status_due.pop_front();
        checked++;
        compare_field("heat_relay", want.heat, got.heat);
        compare_field("cool_relay", want.cool, got.cool);
        compare_field("sensor_fault", want.fault, got.fault);
        compare_field("setpoint_now", want.setpoint, got.setpoint);
        compare_field("corrected_temp", want.temp, got.temp);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no transaction in %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL two_relay_thermostat");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned n;
    int unsigned p;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    kind_i = KIND_TEMP;
    raw_temperature_i = '0;
    up_button_i = 1'b0;
    down_button_i = 1'b0;
    hold_req = 1'b0;
    burst_left = 0;
    mismatches = 0;
    checked = 0;
    cfg_settings = 1;
    cfg = {RST_TEMP_TRIM, RST_HYSTERESIS, RST_OFF_BAND, RST_SETPOINT_MIN, RST_SETPOINT_MAX};
    heat_q = 1'b0;
    cool_q = 1'b0;
    fault_q = 1'b0;
    up_seen = 1'b0;
    down_seen = 1'b0;
    setpoint_q = RST_SETPOINT;
    stored_temp = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: offset 37, hysteresis 10, off band 5, limits 16..35, setpoint 24
    add_row(KIND_BUTTON, 0, 0, 0, 1, 0, 0, 0, 24, 0);
    add_row(KIND_BUTTON, 0, 1, 0, 1, 1, 0, 0, 25, 0);      // poll before any sample
    add_row(KIND_BUTTON, 0, 1, 0, 1, 1, 0, 0, 25, 0);      // held, no step
    add_row(KIND_BUTTON, 0, 0, 0, 1, 1, 0, 0, 25, 0);
    add_row(KIND_BUTTON, 0, 0, 1, 1, 1, 0, 0, 24, 0);
    add_row(KIND_TEMP, 277, 0, 0, 1, 0, 0, 0, 24, 240);
    add_row(KIND_TEMP, 2047, 0, 0, 1, 0, 1, 0, 24, 2010);
    add_row(KIND_TEMP, -2048, 0, 0, 1, 1, 0, 0, 24, -2048); // saturates
    add_row(KIND_FAIL, 0, 0, 0, 1, 0, 0, 1, 24, -2048);
    add_row(KIND_UNUSED, 2047, 1, 1, 1, 0, 0, 1, 24, -2048);
    add_row(KIND_BUTTON, 0, 1, 0, 1, 0, 0, 1, 25, -2048);   // press while faulted
    add_row(KIND_BUTTON, 0, 0, 0, 1, 0, 0, 1, 25, -2048);
    add_row(KIND_TEMP, 282, 0, 0, 1, 0, 0, 0, 25, 245);
    add_row(KIND_TEMP, 294, 0, 0, 1, 0, 0, 0, 25, 257);
    add_row(KIND_TEMP, 298, 0, 0, 1, 0, 1, 0, 25, 261);
    add_row(KIND_TEMP, 294, 0, 0, 1, 0, 1, 0, 25, 257);
    add_row(KIND_TEMP, 292, 0, 0, 1, 0, 0, 0, 25, 255);
    add_row(KIND_TEMP, 276, 0, 0, 1, 1, 0, 0, 25, 239);
    add_row(KIND_TEMP, 277, 0, 0, 1, 1, 0, 0, 25, 240);
    add_row(KIND_BUTTON, 0, 1, 1, 0, 0, 0, 0, 0, 0);
    add_row(KIND_BUTTON, 0, 1, 1, 0, 0, 0, 0, 0, 0);
    add_row(KIND_BUTTON, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(KIND_TEMP, -550, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(KIND_TEMP, 1250, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(KIND_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    foreach (rows[i]) send_item(rows[i].it, rows[i].known, rows[i].want);

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       ;
        1:       configure(0, 0, 0, 0, 127);
        2:       configure(255, 255, 255, 99, 99);
        3:       configure(37, 10, 5, 25, 25);
        4:       configure(20, 30, 60, 60, 20);   // limits crossed
        5:       configure(255, 0, 255, 0, 0);
        default: configure($urandom_range(255), $urandom_range(255), $urandom_range(255),
                           $urandom_range(99), $urandom_range(99));
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == 40) begin
          hold_req = 1'b1;
          burst_left = 120;
        end
        if (p == 0 && n == 120) wait_results();
        send_item(random_item(), 1'b0, '0);
      end
    end
    wait_results();
    repeat (6) @(posedge clk_i);

    $display("Sent %0d samples, %0d failures, %0d button polls, %0d unused kinds",
             kind_count[KIND_TEMP], kind_count[KIND_FAIL], kind_count[KIND_BUTTON],
             kind_count[KIND_UNUSED]);
    $display("%0d register settings, %0d results compared, %0d mismatches",
             cfg_settings, checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS two_relay_thermostat");
    end else begin
      $display("FAIL two_relay_thermostat");
    end
    $finish;
  end

endmodule
